/* rtl/f2dc_pkg.sv */
package f2dc_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned FRAC_DIGITS_W = 4;
  localparam int unsigned FRAC_W        = 64;
  localparam int unsigned MANT_W        = 24;
  localparam int unsigned EXP_W         = 8;

  localparam int unsigned MAX_FRAC_DIGITS_DEF = 9;
  localparam logic [FRAC_DIGITS_W-1:0] FRAC_DIGITS_RESET = 4'd2;

  // Integer part digits of a 32-bit value
  localparam int unsigned INT_DIGITS  = 10;
  localparam int unsigned DIG_CNT_W   = 4;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] SAT_INT     = 32'hFFFF_FFFF;
  // floor(x / 10) == (x * RECIP_TEN) >> DIV_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        DIV_SHIFT   = 35;

  localparam logic [EXP_W-1:0] EXP_ALL_ONES   = 8'hFF;
  localparam logic [EXP_W-1:0] EXP_SUBNORMAL  = 8'd1;
  // Biased exponent at which the mantissa LSB has weight one
  localparam logic [EXP_W-1:0] EXP_UNIT       = 8'd150;
  // Largest exponent whose integer part still fits in 32 bits
  localparam logic [EXP_W-1:0] EXP_INT_MAX    = 8'd158;
  localparam logic [EXP_W-1:0] FRAC_SHIFT_MAX = 8'd64;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  // Classified value: sign to print, integer part, fraction scaled by 2^64
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] ipart;
    logic [FRAC_W-1:0]  frac;
  } item_t;

endpackage

/* rtl/f2dc_front.sv */
module f2dc_front (
  input  logic                         in_valid_i,
  input  logic [f2dc_pkg::VALUE_W-1:0] value_bits_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output f2dc_pkg::item_t              push_item_o,
  input  logic                         push_ready_i
);

  logic                        sign;
  logic [f2dc_pkg::EXP_W-1:0]  expf;
  logic [f2dc_pkg::MANT_W-2:0] man;
  logic [f2dc_pkg::MANT_W-1:0] mant;
  logic [f2dc_pkg::EXP_W-1:0]  exp_eff;
  logic [f2dc_pkg::EXP_W-1:0]  nbits;
  logic [f2dc_pkg::EXP_W-1:0]  shl;
  logic [f2dc_pkg::MANT_W+f2dc_pkg::FRAC_W-1:0] wide;
  f2dc_pkg::item_t             item;

  assign sign    = value_bits_i[31];
  assign expf    = value_bits_i[30:23];
  assign man     = value_bits_i[22:0];
  assign mant    = {(expf != '0), man};
  assign exp_eff = (expf == '0) ? f2dc_pkg::EXP_SUBNORMAL : expf;
  assign nbits   = f2dc_pkg::EXP_UNIT - exp_eff;
  assign shl     = exp_eff - f2dc_pkg::EXP_UNIT;
  assign wide    = {mant, {f2dc_pkg::FRAC_W{1'b0}}} >> nbits[5:0];

  always_comb begin
    item.neg   = sign;
    item.ipart = '0;
    item.frac  = '0;
    if (expf == f2dc_pkg::EXP_ALL_ONES) begin
      // infinity keeps its sign, NaN drops it
      item.ipart = f2dc_pkg::SAT_INT;
      item.neg   = sign & (man == '0);
    end else if (expf == '0 && man == '0) begin
      item.neg = 1'b0;
    end else if (exp_eff >= f2dc_pkg::EXP_UNIT) begin
      if (exp_eff > f2dc_pkg::EXP_INT_MAX) begin
        item.ipart = f2dc_pkg::SAT_INT;
      end else begin
        item.ipart = {8'd0, mant} << shl[3:0];
      end
    end else if (nbits < f2dc_pkg::FRAC_SHIFT_MAX) begin
      item.ipart = {8'd0, wide[f2dc_pkg::MANT_W+f2dc_pkg::FRAC_W-1:f2dc_pkg::FRAC_W]};
      item.frac  = wide[f2dc_pkg::FRAC_W-1:0];
    end
    // values below 2^-40 fall through here and print as all-zero digits
  end

  assign in_stall_o  = !push_ready_i;
  assign push_o      = in_valid_i && push_ready_i;
  assign push_item_o = item;

endmodule

/* rtl/f2dc_queue.sv */
module f2dc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  f2dc_pkg::item_t push_item_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output f2dc_pkg::item_t pop_item_o
);

  localparam int unsigned Depth = f2dc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  f2dc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/f2dc_back.sv */
module f2dc_back #(
  parameter int unsigned MaxFracDigits = f2dc_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [f2dc_pkg::FRAC_DIGITS_W-1:0] frac_digits_i,
  input  logic                               item_valid_i,
  input  f2dc_pkg::item_t                    item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [f2dc_pkg::CHAR_W-1:0]        char_code_o,
  output logic                               last_char_o
);

  localparam int unsigned FracCntW = $clog2(MaxFracDigits + 1);
  localparam int unsigned DigCntW  = f2dc_pkg::DIG_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  logic [f2dc_pkg::VALUE_W-1:0]   x_q, x_d;
  logic [f2dc_pkg::FRAC_W-1:0]    frac_q, frac_d;
  logic                           neg_q, neg_d;
  logic [FracCntW-1:0]            nd_q, nd_d;
  logic [DigCntW-1:0]             cnt_q, cnt_d;
  logic [DigCntW-1:0]             int_left_q, int_left_d;
  logic                           point_q, point_d;
  logic [3:0]                     dig_q [f2dc_pkg::INT_DIGITS];
  logic                           dig_we;

  logic                           ov_q, ov_d;
  logic [f2dc_pkg::CHAR_W-1:0]    char_q, char_d;
  logic                           last_q, last_d;

  logic [2*f2dc_pkg::VALUE_W-1:0] mult;
  logic [f2dc_pkg::VALUE_W-1:0]   quot;
  logic [f2dc_pkg::VALUE_W-1:0]   rem_full;
  logic [3:0]                     digit;
  logic [f2dc_pkg::FRAC_W+3:0]    prod;
  logic [3:0]                     int_dig;
  logic [FracCntW-1:0]            nd_clamp;
  logic                           emit_go;

  // one digit per cycle through a reciprocal multiply
  assign mult     = x_q * f2dc_pkg::RECIP_TEN;
  assign quot     = f2dc_pkg::VALUE_W'(mult >> f2dc_pkg::DIV_SHIFT);
  assign rem_full = x_q - {quot[f2dc_pkg::VALUE_W-4:0], 3'b000}
                        - {quot[f2dc_pkg::VALUE_W-2:0], 1'b0};
  assign digit    = rem_full[3:0];

  // fraction times ten: integer part is the next digit
  assign prod = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);

  assign int_dig  = dig_q[int_left_q - 1'b1];
  assign nd_clamp = (frac_digits_i > f2dc_pkg::FRAC_DIGITS_W'(MaxFracDigits))
                    ? FracCntW'(MaxFracDigits) : FracCntW'(frac_digits_i);
  assign emit_go  = (state_q == ST_EMIT) && (!ov_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    frac_d     = frac_q;
    neg_d      = neg_q;
    nd_d       = nd_q;
    cnt_d      = cnt_q;
    int_left_d = int_left_q;
    point_d    = point_q;
    dig_we     = 1'b0;
    pop_o      = 1'b0;
    ov_d       = ov_q && out_stall_i;
    char_d     = char_q;
    last_d     = last_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          x_d     = item_i.ipart;
          frac_d  = item_i.frac;
          neg_d   = item_i.neg;
          nd_d    = nd_clamp;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dig_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        x_d    = quot;
        if (quot == '0 || cnt_q == DigCntW'(f2dc_pkg::INT_DIGITS - 1)) begin
          int_left_d = cnt_q + 1'b1;
          point_d    = (nd_q != '0);
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          ov_d   = 1'b1;
          last_d = 1'b0;
          if (neg_q) begin
            neg_d  = 1'b0;
            char_d = f2dc_pkg::CHAR_MINUS;
          end else if (int_left_q != '0) begin
            int_left_d = int_left_q - 1'b1;
            char_d     = f2dc_pkg::CHAR_ZERO | {4'd0, int_dig};
            last_d     = (int_left_q == DigCntW'(1)) && (nd_q == '0);
          end else if (point_q) begin
            point_d = 1'b0;
            char_d  = f2dc_pkg::CHAR_POINT;
          end else begin
            nd_d   = nd_q - 1'b1;
            frac_d = prod[f2dc_pkg::FRAC_W-1:0];
            char_d = f2dc_pkg::CHAR_ZERO | {4'd0, prod[f2dc_pkg::FRAC_W+3:f2dc_pkg::FRAC_W]};
            last_d = (nd_q == FracCntW'(1));
          end
          if (last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      neg_q      <= 1'b0;
      nd_q       <= '0;
      cnt_q      <= '0;
      int_left_q <= '0;
      point_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      neg_q      <= neg_d;
      nd_q       <= nd_d;
      cnt_q      <= cnt_d;
      int_left_q <= int_left_d;
      point_q    <= point_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    frac_q <= frac_d;
    char_q <= char_d;
    last_q <= last_d;
    if (dig_we) begin
      dig_q[cnt_q] <= digit;
    end
  end

  assign out_valid_o = ov_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

/* rtl/float_to_decimal_chars_top.sv */
// A value passes the queue, then ST_IDLE, ST_DIV (one step per integer digit, D = 1..10), ST_EMIT.
// A value is sent as 1..21 characters; the back end converts one value at a time,
//   one integer digit per cycle through the reciprocal multiplier, then one character
//   per cycle while out_stall_i is low.
// The two-entry queue lets the front take up to two values while the back end works.
// Reset (rst_ni low, asynchronous): queue and output empty, frac_digits back to 2.
module float_to_decimal_chars_top #(
  parameter int unsigned MaxFracDigits = f2dc_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [f2dc_pkg::FRAC_DIGITS_W-1:0] cfg_frac_digits_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [f2dc_pkg::VALUE_W-1:0]       value_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [f2dc_pkg::CHAR_W-1:0]        char_code_o,
  output logic                               last_char_o
);

  logic [f2dc_pkg::FRAC_DIGITS_W-1:0] frac_digits_q;
  logic                               push;
  logic                               push_ready;
  f2dc_pkg::item_t                    push_item;
  logic                               pop;
  logic                               pop_valid;
  f2dc_pkg::item_t                    pop_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= f2dc_pkg::FRAC_DIGITS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frac_digits_q <= cfg_frac_digits_i;
    end
  end

  f2dc_front u_front (
    .in_valid_i   (in_valid_i),
    .value_bits_i (value_bits_i),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  f2dc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item)
  );

  f2dc_back #(
    .MaxFracDigits (MaxFracDigits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frac_digits_i (frac_digits_q),
    .item_valid_i  (pop_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o)
  );

endmodule
